[hw/rtl/pcpd_pkg.sv]
// Shared constants for the peak-correlation phase derotator.
`timescale 1ns / 1ps

package pcpd_pkg;

  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_PHASE_BITS  = 16;
  localparam int SCORE_BITS      = 16;
  localparam int WIN_BITS        = 16;
  localparam logic [WIN_BITS-1:0] WINDOW_RESET = 16'd256;

  localparam int FIFO_DEPTH = 4;

  // CORDIC angle path: 32-bit signed turn fraction.
  localparam int ANGLE_BITS   = 32;
  localparam int CORDIC_STEPS = 24;
  localparam int GUARD_BITS   = 8;
  localparam int GAIN_BITS    = 30;
  localparam logic signed [GAIN_BITS-1:0] GAIN_Q28 = 30'sd163008219;
  localparam int ROUND_SHIFT  = 36;

  // atan(2^-k) in units of 2^-32 turn
  localparam logic [ANGLE_BITS-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

endpackage

[hw/rtl/pcpd_front.sv]
// Front end: window/tag tracking and phase selection per accepted sample.
`timescale 1ns / 1ps

module pcpd_front #(
  parameter int SAMPLE_BITS = pcpd_pkg::DEF_SAMPLE_BITS,
  parameter int PHASE_BITS  = pcpd_pkg::DEF_PHASE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pcpd_pkg::WIN_BITS-1:0]     cfg_wr_data,
  input  logic                              xfer,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  input  logic signed [SAMPLE_BITS-1:0]     sample_q,
  input  logic                              tag_present,
  input  logic signed [PHASE_BITS-1:0]      tag_phase,
  input  logic signed [pcpd_pkg::SCORE_BITS-1:0] tag_score,
  output logic                              push,
  output logic [2*SAMPLE_BITS+PHASE_BITS-1:0] push_data
);

  logic [pcpd_pkg::WIN_BITS-1:0]          win_len_r;
  logic                                   open_r, open_nxt;
  logic [pcpd_pkg::WIN_BITS-1:0]          cnt_r, cnt_nxt, cnt_mid;
  logic signed [pcpd_pkg::SCORE_BITS-1:0] best_r, best_nxt;
  logic signed [PHASE_BITS-1:0]           phase_r, phase_nxt;

  always_comb begin
    cnt_mid   = cnt_r;
    best_nxt  = best_r;
    phase_nxt = phase_r;
    if (tag_present) begin
      if (!open_r) begin
        cnt_mid   = win_len_r;
        best_nxt  = tag_score;
        phase_nxt = tag_phase;
      end else if (tag_score > best_r) begin
        best_nxt  = tag_score;
        phase_nxt = tag_phase;
      end
    end
    cnt_nxt  = (cnt_mid == '0) ? '0 : cnt_mid - 1'b1;
    open_nxt = (cnt_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r <= pcpd_pkg::WINDOW_RESET;
      open_r    <= 1'b0;
      cnt_r     <= '0;
      best_r    <= '0;
      phase_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        win_len_r <= cfg_wr_data;
      end
      if (xfer) begin
        open_r  <= open_nxt;
        cnt_r   <= cnt_nxt;
        best_r  <= best_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

  // sample goes out with the phase as it stands after this sample's tag
  assign push      = xfer;
  assign push_data = {sample_i, sample_q, phase_nxt};

endmodule

[hw/rtl/pcpd_fifo.sv]
// Small FIFO decoupling the front end from the rotation pipeline.
`timescale 1ns / 1ps

module pcpd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = pcpd_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/pcpd_back.sv]
// Back end: quarter-turn prerotation, pipelined CORDIC, gain and saturation.
`timescale 1ns / 1ps

module pcpd_back #(
  parameter int SAMPLE_BITS = pcpd_pkg::DEF_SAMPLE_BITS,
  parameter int PHASE_BITS  = pcpd_pkg::DEF_PHASE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              src_valid,
  input  logic [2*SAMPLE_BITS+PHASE_BITS-1:0] src_data,
  output logic                              src_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     out_i,
  output logic signed [SAMPLE_BITS-1:0]     out_q
);

  localparam int STEPS = pcpd_pkg::CORDIC_STEPS;
  localparam int AB    = pcpd_pkg::ANGLE_BITS;
  localparam int W     = SAMPLE_BITS + pcpd_pkg::GUARD_BITS + 3;
  localparam int PRW   = W + pcpd_pkg::GAIN_BITS;
  localparam int SHW   = PRW - pcpd_pkg::ROUND_SHIFT;
  localparam logic signed [PRW-1:0] RND = PRW'(64'd1 << (pcpd_pkg::ROUND_SHIFT - 1));

  logic adv;
  logic vld_r [0:STEPS+1];
  logic signed [W-1:0]  xs_r [0:STEPS];
  logic signed [W-1:0]  ys_r [0:STEPS];
  logic signed [AB-1:0] rs_r [0:STEPS-1];
  logic signed [PRW-1:0] px_r, py_r;
  logic out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_i_r, out_q_r;

  // whole pipeline moves together unless a result is held at the output
  assign adv     = !out_valid_r || !out_stall;
  assign src_pop = src_valid && adv;

  // stage 0: exact quarter-turn rotation, residual angle
  logic signed [SAMPLE_BITS-1:0] s_i, s_q;
  logic [PHASE_BITS-1:0] s_ph, neg_ph;
  logic [AB-1:0] ang, ang_rnd, resid;
  logic [1:0] quad;
  logic signed [W-1:0] x_in, y_in, x_pre, y_pre;

  always_comb begin
    s_i     = src_data[2*SAMPLE_BITS+PHASE_BITS-1 -: SAMPLE_BITS];
    s_q     = src_data[SAMPLE_BITS+PHASE_BITS-1 -: SAMPLE_BITS];
    s_ph    = src_data[PHASE_BITS-1:0];
    neg_ph  = PHASE_BITS'(0) - s_ph;
    ang     = {neg_ph, {(AB-PHASE_BITS){1'b0}}};
    ang_rnd = ang + {3'b001, {(AB-3){1'b0}}};
    quad    = ang_rnd[AB-1:AB-2];
    resid   = ang - {quad, {(AB-2){1'b0}}};
    x_in    = W'(s_i) <<< pcpd_pkg::GUARD_BITS;
    y_in    = W'(s_q) <<< pcpd_pkg::GUARD_BITS;
    case (quad)
      2'd1: begin
        x_pre = -y_in;
        y_pre = x_in;
      end
      2'd2: begin
        x_pre = -x_in;
        y_pre = -y_in;
      end
      2'd3: begin
        x_pre = y_in;
        y_pre = -x_in;
      end
      default: begin
        x_pre = x_in;
        y_pre = y_in;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xs_r[0] <= x_pre;
      ys_r[0] <= y_pre;
      rs_r[0] <= $signed(resid);
    end
  end

  // CORDIC micro-rotations, one per stage
  for (genvar k = 0; k < STEPS; k++) begin : g_cordic
    logic signed [W-1:0]  dx, dy;
    logic signed [AB-1:0] atan_k;
    assign dx     = ys_r[k] >>> k;
    assign dy     = xs_r[k] >>> k;
    assign atan_k = $signed(pcpd_pkg::ATAN_TURNS[k]);

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!rs_r[k][AB-1]) begin
          xs_r[k+1] <= xs_r[k] - dx;
          ys_r[k+1] <= ys_r[k] + dy;
        end else begin
          xs_r[k+1] <= xs_r[k] + dx;
          ys_r[k+1] <= ys_r[k] - dy;
        end
      end
    end

    if (k < STEPS - 1) begin : g_ang
      always_ff @(posedge clk) begin
        if (adv) begin
          rs_r[k+1] <= rs_r[k][AB-1] ? rs_r[k] + atan_k : rs_r[k] - atan_k;
        end
      end
    end
  end

  // gain correction
  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= xs_r[STEPS] * pcpd_pkg::GAIN_Q28;
      py_r <= ys_r[STEPS] * pcpd_pkg::GAIN_Q28;
    end
  end

  // round half up, then saturate
  logic signed [PRW-1:0] sum_x, sum_y;
  logic signed [SHW-1:0] sh_x, sh_y;
  logic signed [SAMPLE_BITS-1:0] sat_x, sat_y;
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  always_comb begin
    sum_x = px_r + RND;
    sum_y = py_r + RND;
    sh_x  = sum_x[PRW-1:pcpd_pkg::ROUND_SHIFT];
    sh_y  = sum_y[PRW-1:pcpd_pkg::ROUND_SHIFT];
    if ((&sh_x[SHW-1:SAMPLE_BITS-1]) || !(|sh_x[SHW-1:SAMPLE_BITS-1])) begin
      sat_x = sh_x[SAMPLE_BITS-1:0];
    end else begin
      sat_x = sh_x[SHW-1] ? SAT_MIN : SAT_MAX;
    end
    if ((&sh_y[SHW-1:SAMPLE_BITS-1]) || !(|sh_y[SHW-1:SAMPLE_BITS-1])) begin
      sat_y = sh_y[SAMPLE_BITS-1:0];
    end else begin
      sat_y = sh_y[SHW-1] ? SAT_MIN : SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_i_r <= sat_x;
      out_q_r <= sat_y;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= STEPS + 1; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= src_pop;
      for (int i = 1; i <= STEPS + 1; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[STEPS+1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_i     = out_i_r;
  assign out_q     = out_q_r;

endmodule

[hw/rtl/peak_corr_phase_derotator_top.sv]
// Top level of the peak-correlation phase derotator.
`timescale 1ns / 1ps

// From input transfer to out_valid a sample passes the FIFO write, prerotation,
//   24 CORDIC stages (fully pipelined, one per micro-rotation), gain multiply, round/saturate.
// Throughput: one sample per cycle while out_stall does not hold the output.
// Reset (rst_n low, synchronous): window closed, countdown, score and held phase cleared,
//   window_length back to 256, FIFO and pipeline emptied; no clearing pass.

module peak_corr_phase_derotator_top #(
  parameter int SAMPLE_BITS = pcpd_pkg::DEF_SAMPLE_BITS,
  parameter int PHASE_BITS  = pcpd_pkg::DEF_PHASE_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration: window_length
  input  logic                                   cfg_wr_en,
  input  logic [pcpd_pkg::WIN_BITS-1:0]          cfg_wr_data,
  // sample input
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]          in_sample_q,
  input  logic                                   in_tag_present,
  input  logic signed [PHASE_BITS-1:0]           in_tag_phase,
  input  logic signed [pcpd_pkg::SCORE_BITS-1:0] in_tag_score,
  // derotated output
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [SAMPLE_BITS-1:0]          out_i,
  output logic signed [SAMPLE_BITS-1:0]          out_q
);

  localparam int QW = 2 * SAMPLE_BITS + PHASE_BITS;

  logic          in_xfer;
  logic          q_push, q_full, q_pop, q_not_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  // stall only on a full queue; registered count, so no path from out_stall
  assign in_stall = q_full;
  assign in_xfer  = in_valid && !q_full;

  // front: window bookkeeping, tags pick the phase each sample is rotated by
  pcpd_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .xfer       (in_xfer),
    .sample_i   (in_sample_i),
    .sample_q   (in_sample_q),
    .tag_present(in_tag_present),
    .tag_phase  (in_tag_phase),
    .tag_score  (in_tag_score),
    .push       (q_push),
    .push_data  (q_wdata)
  );

  // queue carries {sample_i, sample_q, phase} to the rotator
  pcpd_fifo #(
    .WIDTH(QW),
    .DEPTH(pcpd_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_data (q_rdata)
  );

  // back: rotate by the negated phase, gain-correct and saturate
  pcpd_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .PHASE_BITS (PHASE_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .src_valid(q_not_empty),
    .src_data (q_rdata),
    .src_pop  (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_i    (out_i),
    .out_q    (out_q)
  );

endmodule
